[rtl/pwm_fade_ramp_engine_top_assert.svh]
// assertion macros used by the rtl top level
`ifndef PWM_FADE_RAMP_ENGINE_TOP_ASSERT_SVH
`define PWM_FADE_RAMP_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PFRE_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pfre check failed: same cycle");

// next-cycle implication
`define PFRE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pfre check failed: next cycle");

`endif

[rtl/pfre_pkg.sv]
package pfre_pkg;

   localparam int DIV_NW = 32;
   localparam int DIV_DW = 17;

   localparam logic [15:0] PERIOD_RESET = 16'd1000;
   localparam logic [9:0]  IVL_RESET    = 10'd10;

   // floor(x / 100000) as (x * SCALE_RECIP) >> SCALE_SHIFT, exact for x below 2**26
   localparam logic [26:0] SCALE_RECIP = 27'd87960931;
   localparam int          SCALE_SHIFT = 43;

   localparam logic       OP_TICK = 1'b0;
   localparam logic       OP_SET  = 1'b1;

   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_ON     = 2'd1;
   localparam logic [1:0] MODE_ONCE   = 2'd2;
   localparam logic [1:0] MODE_REPEAT = 2'd3;

   localparam logic REG_PERIOD = 1'b0;
   localparam logic REG_IVL    = 1'b1;

   typedef struct packed {
      logic [15:0] goal;
      logic [15:0] alt;
      logic [15:0] rate;
      logic [31:0] hold;
      logic [1:0]  mode;
      logic [15:0] step;
      logic [15:0] level;
      logic [31:0] steps;
      logic [9:0]  icount;
      logic [9:0]  ivl;
   } entry_type;

endpackage

[rtl/pfre_req_if.sv]
interface pfre_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [2:0]  channel;
   logic [15:0] target_level;
   logic [15:0] other_level;
   logic [15:0] rate_percent;
   logic [31:0] hold_ms;
   logic [1:0]  mode;

   modport source (output valid, opcode, channel, target_level, other_level, rate_percent,
                   hold_ms, mode, input ready);
   modport sink (input valid, opcode, channel, target_level, other_level, rate_percent,
                 hold_ms, mode, output ready);
endinterface

[rtl/pfre_rsp_if.sv]
interface pfre_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  out_channel;
   logic [15:0] duty;
   logic        last;

   modport source (output valid, out_channel, duty, last, input ready);
   modport sink (input valid, out_channel, duty, last, output ready);
endinterface

[rtl/pfre_div.sv]
module pfre_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pfre_pkg::DIV_NW-1:0]  num,
   input  logic [pfre_pkg::DIV_DW-1:0]  den,
   output logic                         busy,
   output logic                         done,
   output logic [pfre_pkg::DIV_NW-1:0]  quo,
   output logic [pfre_pkg::DIV_DW-1:0]  rem
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [pfre_pkg::DIV_NW-1:0] quo_ff, quo_in;
   logic [pfre_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [pfre_pkg::DIV_DW-1:0] den_ff, den_in;
   logic [pfre_pkg::DIV_DW:0]   trial;
   logic [pfre_pkg::DIV_DW:0]   diff;

   assign trial = {rem_ff, quo_ff[pfre_pkg::DIV_NW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[pfre_pkg::DIV_DW-1:0];
            quo_in = {quo_ff[pfre_pkg::DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[pfre_pkg::DIV_DW-1:0];
            quo_in = {quo_ff[pfre_pkg::DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

[rtl/pwm_fade_ramp_engine_top.sv]
// channel     dir   handshake          payload
// req_bus     in    valid/ready        opcode channel target_level other_level
//                                      rate_percent hold_ms mode
// rsp_bus     out   valid/ready        out_channel duty last
// csr_*       in    apb write/read     duty full scale @0x0, step_interval_ms @0x4
//
// a set transaction reads the channel, derives the step and runs the divider for the
// step count unless already at target; a tick walks every channel, skipping an idle
// one, writing back a counting one and recomputing one that starts a hold or reloads
// channel state lives in one memory, one channel read-modify-written at a time
// reset is synchronous; memory entries read as zero until first written
// a stalled rsp_bus holds the walk once the output and pending slots are full

`include "pwm_fade_ramp_engine_top_assert.svh"

module pwm_fade_ramp_engine_top #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   pfre_req_if.sink    req_bus,
   pfre_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [AW-1:0] LAST_CH = AW'(NUM_CHANNELS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RD     = 4'd1;
   localparam logic [3:0] S_EVAL   = 4'd2;
   localparam logic [3:0] S_HDIV   = 4'd3;
   localparam logic [3:0] S_LSCALE = 4'd4;
   localparam logic [3:0] S_LMUL   = 4'd5;
   localparam logic [3:0] S_LDIST  = 4'd6;
   localparam logic [3:0] S_LDIV2  = 4'd7;
   localparam logic [3:0] S_WB     = 4'd8;
   localparam logic [3:0] S_FLUSH  = 4'd9;

   logic [15:0] period_ff;
   logic [9:0]  ivl_cfg_ff;

   logic [3:0]  state_ff, state_in;
   logic [AW-1:0] ch_ff, ch_in;
   logic        cmd_ff, cmd_in;
   logic        emit_ff, emit_in;
   pfre_pkg::entry_type w_ff, w_in;
   logic [9:0]  q_ff, q_in;
   logic [25:0] scale_ff, scale_in;

   logic        pend_valid_ff, pend_valid_in;
   logic [2:0]  pend_ch_ff, pend_ch_in;
   logic [15:0] pend_duty_ff, pend_duty_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_ch_ff, out_ch_in;
   logic [15:0] out_duty_ff, out_duty_in;
   logic        out_last_ff, out_last_in;

   logic [2:0]  c_ch_ff;
   logic [15:0] c_tgt_ff, c_alt_ff, c_rate_ff;
   logic [31:0] c_hold_ff;
   logic [1:0]  c_mode_ff;

   pfre_pkg::entry_type mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] vld_ff;
   pfre_pkg::entry_type rd_ff;
   logic        rd_vld_ff;
   logic        mem_we;

   logic        div_start;
   logic [31:0] div_num;
   logic [16:0] div_den;
   logic        div_busy, div_done;
   logic [31:0] div_quo;
   logic [16:0] div_rem;

   pfre_pkg::entry_type e;
   logic [9:0]  ic_dec;
   logic [31:0] steps_dec;
   logic [52:0] recip_prod;
   logic [25:0] rate_prod;
   logic [15:0] step_raw;
   logic [15:0] lvl_new;
   logic        out_free;
   logic        req_acc;
   logic        cfg_wr;

   // configuration
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= pfre_pkg::PERIOD_RESET;
         ivl_cfg_ff <= pfre_pkg::IVL_RESET;
      end else if (cfg_wr) begin
         unique case (csr_paddr[2])
            pfre_pkg::REG_PERIOD: period_ff  <= csr_pwdata[15:0];
            pfre_pkg::REG_IVL:    ivl_cfg_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         pfre_pkg::REG_PERIOD: csr_prdata = {16'd0, period_ff};
         pfre_pkg::REG_IVL:    csr_prdata = {22'd0, ivl_cfg_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // channel memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ch_ff] <= w_ff;
      end
      rd_ff <= mem[ch_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[ch_ff] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[ch_ff];
      end
   end

   pfre_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign e          = rd_vld_ff ? rd_ff : '0;
   assign ic_dec     = e.icount - 10'd1;
   assign steps_dec  = e.steps - 32'd1;
   assign scale_in   = period_ff * ivl_cfg_ff;
   assign recip_prod = scale_ff * pfre_pkg::SCALE_RECIP;
   assign rate_prod  = q_ff * w_ff.rate;
   assign step_raw   = (w_ff.rate != 16'd0) ? rate_prod[15:0] : period_ff;
   assign lvl_new    = (w_ff.mode == pfre_pkg::MODE_REPEAT && w_ff.goal > w_ff.alt) ?
                       w_ff.alt : w_ff.level;
   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign req_acc    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      cmd_in        = cmd_ff;
      emit_in       = emit_ff;
      w_in          = w_ff;
      q_in          = q_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      pend_duty_in  = pend_duty_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_ch_in     = out_ch_ff;
      out_duty_in   = out_duty_ff;
      out_last_in   = out_last_ff;
      mem_we        = 1'b0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_bus.opcode == pfre_pkg::OP_SET) begin
                  if (32'(req_bus.channel) < NUM_CHANNELS) begin
                     ch_in    = AW'(req_bus.channel);
                     cmd_in   = 1'b1;
                     emit_in  = 1'b0;
                     state_in = S_RD;
                  end
               end else begin
                  ch_in    = '0;
                  cmd_in   = 1'b0;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            w_in    = e;
            emit_in = 1'b0;
            if (cmd_ff) begin
               w_in.goal = c_tgt_ff;
               w_in.alt  = c_alt_ff;
               w_in.rate = c_rate_ff;
               w_in.hold = c_hold_ff;
               w_in.mode = c_mode_ff;
               w_in.ivl  = ivl_cfg_ff;
               state_in  = S_LSCALE;
            end else if (e.icount == 10'd0) begin
               if (ch_ff == LAST_CH) begin
                  state_in = S_FLUSH;
               end else begin
                  ch_in    = ch_ff + AW'(1);
                  state_in = S_RD;
               end
            end else if (ic_dec != 10'd0) begin
               w_in.icount = ic_dec;
               state_in    = S_WB;
            end else begin
               w_in.icount = 10'd0;
               w_in.steps  = steps_dec;
               state_in    = S_WB;
               if (e.level == e.goal && e.hold != 32'd0) begin
                  if (steps_dec != 32'd0) begin
                     w_in.icount = e.ivl;
                  end else if (e.mode == pfre_pkg::MODE_ONCE ||
                               e.mode == pfre_pkg::MODE_REPEAT) begin
                     w_in.goal = e.alt;
                     w_in.alt  = e.goal;
                     w_in.ivl  = ivl_cfg_ff;
                     if (e.mode == pfre_pkg::MODE_ONCE) begin
                        w_in.hold = 32'd0;
                        w_in.mode = pfre_pkg::MODE_ON;
                     end
                     state_in  = S_LSCALE;
                  end else begin
                     w_in.hold = 32'd0;
                  end
               end else begin
                  emit_in = 1'b1;
                  if (steps_dec != 32'd0) begin
                     w_in.level  = (e.goal >= e.level) ? e.level + e.step :
                                   e.level - e.step;
                     w_in.icount = e.ivl;
                  end else begin
                     w_in.level = e.goal;
                     if (e.hold != 32'd0) begin
                        div_start = 1'b1;
                        div_num   = e.hold;
                        div_den   = {7'd0, e.ivl};
                        state_in  = S_HDIV;
                     end else if (e.mode == pfre_pkg::MODE_ONCE ||
                                  e.mode == pfre_pkg::MODE_REPEAT) begin
                        w_in.goal = e.alt;
                        w_in.alt  = e.goal;
                        w_in.ivl  = ivl_cfg_ff;
                        if (e.mode == pfre_pkg::MODE_ONCE) begin
                           w_in.hold = 32'd0;
                           w_in.mode = pfre_pkg::MODE_ON;
                        end
                        state_in  = S_LSCALE;
                     end else begin
                        w_in.hold = 32'd0;
                     end
                  end
               end
            end
         end
         S_HDIV: begin
            if (div_done) begin
               w_in.steps  = (w_ff.ivl != 10'd0) ? div_quo : 32'd0;
               w_in.icount = (w_ff.ivl != 10'd0 && div_quo != 32'd0) ? w_ff.ivl : 10'd0;
               state_in    = S_WB;
            end
         end
         S_LSCALE: begin
            q_in     = recip_prod[pfre_pkg::SCALE_SHIFT +: 10];
            state_in = S_LMUL;
         end
         S_LMUL: begin
            w_in.step = (step_raw == 16'd0) ? 16'd1 : step_raw;
            state_in  = S_LDIST;
         end
         S_LDIST: begin
            w_in.level  = lvl_new;
            w_in.icount = w_ff.ivl;
            if (w_ff.goal == lvl_new) begin
               w_in.steps = 32'd1;
               state_in   = S_WB;
            end else begin
               div_start = 1'b1;
               div_num   = {16'd0, (w_ff.goal > lvl_new) ? w_ff.goal - lvl_new :
                                                         lvl_new - w_ff.goal};
               div_den   = {1'b0, w_ff.step};
               state_in  = S_LDIV2;
            end
         end
         S_LDIV2: begin
            if (div_done) begin
               w_in.steps = div_quo + {31'd0, (div_rem != 17'd0)};
               state_in   = S_WB;
            end
         end
         S_WB: begin
            if (!(emit_ff && pend_valid_ff && !out_free)) begin
               mem_we = 1'b1;
               if (emit_ff) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_ch_in    = pend_ch_ff;
                     out_duty_in  = pend_duty_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_ch_in    = 3'(ch_ff);
                  pend_duty_in  = w_ff.level;
               end
               if (cmd_ff) begin
                  state_in = S_IDLE;
               end else if (ch_ff == LAST_CH) begin
                  state_in = S_FLUSH;
               end else begin
                  ch_in    = ch_ff + AW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_ch_in     = pend_ch_ff;
               out_duty_in   = pend_duty_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ch_ff         <= '0;
         cmd_ff        <= 1'b0;
         emit_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         cmd_ff        <= cmd_in;
         emit_ff       <= emit_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      w_ff         <= w_in;
      q_ff         <= q_in;
      scale_ff     <= scale_in;
      pend_ch_ff   <= pend_ch_in;
      pend_duty_ff <= pend_duty_in;
      out_ch_ff    <= out_ch_in;
      out_duty_ff  <= out_duty_in;
      out_last_ff  <= out_last_in;
      if (req_acc) begin
         c_ch_ff   <= req_bus.channel;
         c_tgt_ff  <= req_bus.target_level;
         c_alt_ff  <= req_bus.other_level;
         c_rate_ff <= req_bus.rate_percent;
         c_hold_ff <= req_bus.hold_ms;
         c_mode_ff <= req_bus.mode;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_channel = out_ch_ff;
   assign rsp_bus.duty        = out_duty_ff;
   assign rsp_bus.last        = out_last_ff;

   `PFRE_ASSERT_SAME(a_idle_no_pend, clock, reset, state_ff == S_IDLE, !pend_valid_ff)
   `PFRE_ASSERT_SAME(a_div_start_free, clock, reset, div_start, !div_busy)
   `PFRE_ASSERT_SAME(a_cmd_no_emit, clock, reset, state_ff == S_WB && cmd_ff, !emit_ff)
   `PFRE_ASSERT_SAME(a_cmd_in_range, clock, reset, cmd_ff && state_ff == S_EVAL,
      32'(c_ch_ff) < NUM_CHANNELS)
   `PFRE_ASSERT_NEXT(a_flush_last, clock, reset,
      state_ff == S_FLUSH && pend_valid_ff && out_free, out_valid_ff && out_last_ff)

endmodule
